### rtl/adcba_pkg.sv
`default_nettype none

package adcba_pkg;

    // Number of converter channels carried in one sample frame.
    localparam int NUM_CH = 6;

    // Fixed field widths.
    localparam int GAIN_W      = 24;
    localparam int VOFFS_W     = 16;
    localparam int OUT_W       = 18;
    localparam int TEMP_W      = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int OUT_TDATA_W = 112;

    // Saturation limits of the converted fields.
    localparam int OUT_MAX  = 131071;
    localparam int OUT_MIN  = -131072;
    localparam int TEMP_MAX = 32767;

    // Calibration defaults after reset.
    localparam logic [GAIN_W-1:0]         RST_CHASSIS_VOLT_GAIN   = 24'd539034;
    localparam logic signed [VOFFS_W-1:0] RST_CHASSIS_VOLT_OFFSET = 16'sd6;
    localparam logic [GAIN_W-1:0]         RST_CAP_VOLT_GAIN       = 24'd537854;
    localparam logic signed [VOFFS_W-1:0] RST_CAP_VOLT_OFFSET     = 16'sd14;
    localparam logic [GAIN_W-1:0]         RST_CURRENT_GAIN        = 24'd1320321;
    localparam logic signed [OUT_W-1:0]   RST_CURRENT_OFFSET      = -18'sd41250;

    // Register indexes of the configuration channel.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHASSIS_VOLT_GAIN   = 3'd0,
        CFG_CHASSIS_VOLT_OFFSET = 3'd1,
        CFG_CAP_VOLT_GAIN       = 3'd2,
        CFG_CAP_VOLT_OFFSET     = 3'd3,
        CFG_CURRENT_GAIN        = 3'd4,
        CFG_CURRENT_OFFSET      = 3'd5
    } cfg_idx_t;

    // Load enables of the conversion pipeline stages.
    typedef struct packed {
        logic ld_prod;
        logic ld_round;
        logic ld_recip;
        logic ld_corr;
        logic ld_out;
    } pipe_ctl_t;

endpackage

`default_nettype wire

### rtl/adcba_accum.sv
`default_nettype none

module adcba_accum #(
    parameter int BLOCK_FRAMES = 8,
    parameter int SAMPLE_BITS  = 12,
    parameter int SUM_W        = 15
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] samples [adcba_pkg::NUM_CH],
    output logic                        snap_valid,
    input  wire logic                   snap_ready,
    output logic [SUM_W-1:0]            snap_sums [adcba_pkg::NUM_CH]
);
    import adcba_pkg::*;

    localparam int CNT_W = (BLOCK_FRAMES > 2) ? $clog2(BLOCK_FRAMES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_FRAMES - 1);

    logic [SUM_W-1:0] sums_reg [NUM_CH];
    logic [SUM_W-1:0] sums_next [NUM_CH];
    logic [SUM_W-1:0] add_sums [NUM_CH];
    logic [SUM_W-1:0] snap_reg [NUM_CH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             snap_valid_reg;
    logic             snap_valid_next;
    logic             last_frame;
    logic             accept;

    assign last_frame = (count_reg == CNT_LAST);
    // A frame that closes a block needs the snapshot stage to be free or draining.
    assign in_ready   = !last_frame || !snap_valid_reg || snap_ready;
    assign accept     = in_valid && in_ready;

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            add_sums[i]  = sums_reg[i] + SUM_W'(samples[i]);
            sums_next[i] = sums_reg[i];
            if (accept)
            begin
                sums_next[i] = last_frame ? '0 : add_sums[i];
            end
        end
        count_next = count_reg;
        if (accept)
        begin
            count_next = last_frame ? '0 : count_reg + CNT_W'(1);
        end
        snap_valid_next = snap_valid_reg;
        if (accept && last_frame)
        begin
            snap_valid_next = 1'b1;
        end
        else if (snap_ready)
        begin
            snap_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                sums_reg[i] <= '0;
            end
            count_reg      <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            sums_reg       <= sums_next;
            count_reg      <= count_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_frame)
        begin
            snap_reg <= add_sums;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap_sums  = snap_reg;

    a_block_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_frame) |=> (count_reg == '0) && snap_valid_reg)
        else $error("block did not restart after its last frame");

    a_snap_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (snap_valid_reg && !snap_ready) |-> !(accept && last_frame))
        else $error("pending snapshot overwritten by a new block");

endmodule

`default_nettype wire

### rtl/adcba_flow.sv
`default_nettype none

module adcba_flow (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           snap_valid,
    output logic                snap_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output adcba_pkg::pipe_ctl_t ctl
);
    import adcba_pkg::*;

    // Stage 1 products, 2 rounding, 3 reciprocal, 4 correction, 5 output.
    logic [5:1] valid_reg;
    logic [5:1] valid_next;
    logic [6:1] rdy;
    logic [5:1] vin;
    logic [5:1] load;

    always_comb
    begin
        rdy[6] = out_ready;
        for (int i = 5; i >= 1; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        vin[1] = snap_valid;
        for (int i = 2; i <= 5; i++)
        begin
            vin[i] = valid_reg[i-1];
        end
        for (int i = 1; i <= 5; i++)
        begin
            load[i]       = rdy[i] && vin[i];
            valid_next[i] = rdy[i] ? vin[i] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign snap_ready  = rdy[1];
    assign out_valid   = valid_reg[5];
    assign ctl.ld_prod  = load[1];
    assign ctl.ld_round = load[2];
    assign ctl.ld_recip = load[3];
    assign ctl.ld_corr  = load[4];
    assign ctl.ld_out   = load[5];

endmodule

`default_nettype wire

### rtl/adcba_convert.sv
`default_nettype none

module adcba_convert #(
    parameter int BLOCK_FRAMES = 8,
    parameter int SUM_W        = 15
) (
    input  wire logic                                clk,
    input  wire adcba_pkg::pipe_ctl_t                ctl,
    input  wire logic [SUM_W-1:0]                    sum,
    input  wire logic [adcba_pkg::GAIN_W-1:0]        gain,
    input  wire logic signed [adcba_pkg::OUT_W-1:0]  offset,
    output logic signed [adcba_pkg::OUT_W-1:0]       result
);
    import adcba_pkg::*;

    localparam int PROD_W = SUM_W + GAIN_W;
    localparam int Y_W    = PROD_W + 1 - 16;
    localparam int R_W    = Y_W + 7;
    localparam int V_W    = Y_W + 2;
    localparam logic [PROD_W:0]  HALF  = (PROD_W + 1)'(BLOCK_FRAMES * 32768);
    // floor(2^Y_W / BLOCK_FRAMES): the estimate is low by at most one.
    localparam logic [Y_W-1:0]   RECIP = Y_W'((64'd1 << Y_W) / BLOCK_FRAMES);
    localparam logic [R_W-1:0]   BF    = R_W'(BLOCK_FRAMES);
    localparam logic signed [V_W-1:0] SAT_HI = V_W'(OUT_MAX);
    localparam logic signed [V_W-1:0] SAT_LO = V_W'(OUT_MIN);

    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [Y_W-1:0]         y_reg, y_next;
    logic [Y_W-1:0]         y_d_reg;
    logic [2*Y_W-1:0]       est;
    logic [Y_W-1:0]         qe_reg, qe_next;
    logic [R_W-1:0]         rem;
    logic [Y_W-1:0]         q_reg, q_next;
    logic signed [V_W-1:0]  val;
    logic signed [OUT_W-1:0] result_reg, result_next;

    always_comb
    begin
        prod_next = PROD_W'(sum) * PROD_W'(gain);
        y_next    = Y_W'(({1'b0, prod_reg} + HALF) >> 16);
        est       = (2*Y_W)'(y_reg) * (2*Y_W)'(RECIP);
        qe_next   = est[2*Y_W-1:Y_W];
        rem       = R_W'(y_d_reg) - R_W'(qe_reg) * BF;
        q_next    = qe_reg + Y_W'(rem >= BF);
        val       = $signed({2'b00, q_reg}) + {{(V_W-OUT_W){offset[OUT_W-1]}}, offset};
        if (val > SAT_HI)
        begin
            result_next = OUT_W'(SAT_HI);
        end
        else if (val < SAT_LO)
        begin
            result_next = OUT_W'(SAT_LO);
        end
        else
        begin
            result_next = OUT_W'(val);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_prod)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.ld_round)
        begin
            y_reg <= y_next;
        end
        if (ctl.ld_recip)
        begin
            qe_reg  <= qe_next;
            y_d_reg <= y_reg;
        end
        if (ctl.ld_corr)
        begin
            q_reg <= q_next;
        end
        if (ctl.ld_out)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

    a_estimate_close: assert property (@(posedge clk)
        ctl.ld_corr |-> (rem < (BF << 1)))
        else $error("reciprocal quotient estimate off by more than one");

endmodule

`default_nettype wire

### rtl/adc_block_average_calibrate_core.sv
`default_nettype none

// Block average and calibration of converter sample frames.
//
// The input stream carries one frame of six converter codes per request. Each code is
// added to a running sum for its channel; every BLOCK_FRAMES frames the sums are frozen
// into a snapshot and cleared, and one result request leaves on the output stream. The
// voltage channels and the three current channels come out as gain times mean plus
// offset, rounded to nearest and saturated to 18 bits; temperature comes out as its raw
// block sum, saturated to 15 bits.
//
// Frames are taken at one per clock cycle while s_tready is high, so one result leaves per
// BLOCK_FRAMES accepted frames. A result shows on m_tvalid once the frame that closes its
// block is accepted and has passed one snapshot register, then a product stage, a rounding
// stage, a reciprocal multiply that divides by BLOCK_FRAMES, a quotient correction, and the
// offset and saturation stage feeding the output register.
//
// Reset clears the sums, the frame count and all valid flags, and loads the calibration
// registers with their defaults. When the receiver stalls, results wait in the pipeline
// and frames are still taken; only a frame that would close another block is held off,
// and only while the snapshot register is still occupied. Configuration writes are
// always accepted and should be made while no block is in flight.
module adc_block_average_calibrate_core #(
    parameter int BLOCK_FRAMES = 8,
    parameter int SAMPLE_BITS  = 12
) (
    input  wire logic clk,
    input  wire logic rst_n,

    // Sample frame input.
    input  wire logic                                          s_tvalid,
    output logic                                               s_tready,
    // raw_chassis_volt, raw_referee_current, raw_chassis_current, raw_cap_current,
    // raw_temperature, raw_cap_volt, each SAMPLE_BITS wide, zero padded to bytes.
    input  wire logic [((6*SAMPLE_BITS+7)/8)*8-1:0]            s_tdata,

    // Result output.
    output logic                                               m_tvalid,
    input  wire logic                                          m_tready,
    // chassis_volt_mv 18s, cap_volt_mv 18s, referee_current_ma 18s,
    // chassis_current_ma 18s, cap_current_ma 18s, temperature_sum 15u, zero padded.
    output logic [adcba_pkg::OUT_TDATA_W-1:0]                  m_tdata,

    // Configuration write channel.
    input  wire logic                                          cfg_valid,
    output logic                                               cfg_ready,
    input  wire logic [adcba_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  wire logic [adcba_pkg::CFG_DATA_W-1:0]              cfg_data
);
    import adcba_pkg::*;

    // A block sum of BLOCK_FRAMES codes always fits in this width.
    localparam int SUM_W = SAMPLE_BITS + ((BLOCK_FRAMES > 2) ? $clog2(BLOCK_FRAMES) : 1);
    localparam int T_W   = (SUM_W > TEMP_W) ? SUM_W : TEMP_W;
    localparam logic [T_W-1:0] TEMP_CAP = T_W'(TEMP_MAX);
    localparam int TEMP_CH = 4;

    // Calibration registers.
    logic [GAIN_W-1:0]         chassis_volt_gain_reg;
    logic signed [VOFFS_W-1:0] chassis_volt_offset_reg;
    logic [GAIN_W-1:0]         cap_volt_gain_reg;
    logic signed [VOFFS_W-1:0] cap_volt_offset_reg;
    logic [GAIN_W-1:0]         current_gain_reg;
    logic signed [OUT_W-1:0]   current_offset_reg;

    logic [SAMPLE_BITS-1:0] samples [NUM_CH];
    logic [SUM_W-1:0]       snap_sums [NUM_CH];
    logic                   snap_valid;
    logic                   snap_ready;
    pipe_ctl_t              ctl;

    logic signed [OUT_W-1:0] chassis_volt_off18;
    logic signed [OUT_W-1:0] cap_volt_off18;
    logic signed [OUT_W-1:0] chassis_volt_mv;
    logic signed [OUT_W-1:0] cap_volt_mv;
    logic signed [OUT_W-1:0] referee_current_ma;
    logic signed [OUT_W-1:0] chassis_current_ma;
    logic signed [OUT_W-1:0] cap_current_ma;

    // Temperature sum rides along the conversion pipeline.
    logic [SUM_W-1:0]  temp_pipe_reg [1:4];
    logic [T_W-1:0]    temp_wide;
    logic [TEMP_W-1:0] temp_out_reg, temp_out_next;

    // The configuration channel never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chassis_volt_gain_reg   <= RST_CHASSIS_VOLT_GAIN;
            chassis_volt_offset_reg <= RST_CHASSIS_VOLT_OFFSET;
            cap_volt_gain_reg       <= RST_CAP_VOLT_GAIN;
            cap_volt_offset_reg     <= RST_CAP_VOLT_OFFSET;
            current_gain_reg        <= RST_CURRENT_GAIN;
            current_offset_reg      <= RST_CURRENT_OFFSET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CHASSIS_VOLT_GAIN:   chassis_volt_gain_reg   <= cfg_data;
                CFG_CHASSIS_VOLT_OFFSET: chassis_volt_offset_reg <= cfg_data[VOFFS_W-1:0];
                CFG_CAP_VOLT_GAIN:       cap_volt_gain_reg       <= cfg_data;
                CFG_CAP_VOLT_OFFSET:     cap_volt_offset_reg     <= cfg_data[VOFFS_W-1:0];
                CFG_CURRENT_GAIN:        current_gain_reg        <= cfg_data;
                CFG_CURRENT_OFFSET:      current_offset_reg      <= cfg_data[OUT_W-1:0];
                default:
                begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // Unpack the frame; fields sit from the lowest bit up in channel order.
    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            samples[i] = s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
        end
    end

    adcba_accum #(
        .BLOCK_FRAMES (BLOCK_FRAMES),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .SUM_W        (SUM_W)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .samples    (samples),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap_sums  (snap_sums)
    );

    adcba_flow u_flow (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .ctl        (ctl)
    );

    // The voltage offsets are sign extended to the common offset width.
    assign chassis_volt_off18 = OUT_W'(chassis_volt_offset_reg);
    assign cap_volt_off18     = OUT_W'(cap_volt_offset_reg);

    // Snapshot order is the frame order: chassis V, referee I, chassis I, cap I,
    // temperature, cap V.
    adcba_convert #(.BLOCK_FRAMES(BLOCK_FRAMES), .SUM_W(SUM_W)) u_conv_chassis_volt (
        .clk    (clk),
        .ctl    (ctl),
        .sum    (snap_sums[0]),
        .gain   (chassis_volt_gain_reg),
        .offset (chassis_volt_off18),
        .result (chassis_volt_mv)
    );

    adcba_convert #(.BLOCK_FRAMES(BLOCK_FRAMES), .SUM_W(SUM_W)) u_conv_cap_volt (
        .clk    (clk),
        .ctl    (ctl),
        .sum    (snap_sums[5]),
        .gain   (cap_volt_gain_reg),
        .offset (cap_volt_off18),
        .result (cap_volt_mv)
    );

    adcba_convert #(.BLOCK_FRAMES(BLOCK_FRAMES), .SUM_W(SUM_W)) u_conv_referee_current (
        .clk    (clk),
        .ctl    (ctl),
        .sum    (snap_sums[1]),
        .gain   (current_gain_reg),
        .offset (current_offset_reg),
        .result (referee_current_ma)
    );

    adcba_convert #(.BLOCK_FRAMES(BLOCK_FRAMES), .SUM_W(SUM_W)) u_conv_chassis_current (
        .clk    (clk),
        .ctl    (ctl),
        .sum    (snap_sums[2]),
        .gain   (current_gain_reg),
        .offset (current_offset_reg),
        .result (chassis_current_ma)
    );

    adcba_convert #(.BLOCK_FRAMES(BLOCK_FRAMES), .SUM_W(SUM_W)) u_conv_cap_current (
        .clk    (clk),
        .ctl    (ctl),
        .sum    (snap_sums[3]),
        .gain   (current_gain_reg),
        .offset (current_offset_reg),
        .result (cap_current_ma)
    );

    // Temperature is only delayed, then clipped to its field at the output stage.
    always_comb
    begin
        temp_wide = T_W'(temp_pipe_reg[4]);
        if (temp_wide > TEMP_CAP)
        begin
            temp_out_next = TEMP_W'(TEMP_CAP);
        end
        else
        begin
            temp_out_next = TEMP_W'(temp_wide);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_prod)
        begin
            temp_pipe_reg[1] <= snap_sums[TEMP_CH];
        end
        if (ctl.ld_round)
        begin
            temp_pipe_reg[2] <= temp_pipe_reg[1];
        end
        if (ctl.ld_recip)
        begin
            temp_pipe_reg[3] <= temp_pipe_reg[2];
        end
        if (ctl.ld_corr)
        begin
            temp_pipe_reg[4] <= temp_pipe_reg[3];
        end
        if (ctl.ld_out)
        begin
            temp_out_reg <= temp_out_next;
        end
    end

    assign m_tdata = {
        {(OUT_TDATA_W - 5*OUT_W - TEMP_W){1'b0}},
        temp_out_reg,
        cap_current_ma,
        chassis_current_ma,
        referee_current_ma,
        cap_volt_mv,
        chassis_volt_mv
    };

    a_out_valid_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(ctl.ld_out))
        else $error("result raised without an output stage load");

endmodule

`default_nettype wire

### bench/adcba_calibration_checker.sv
module adcba_calibration_checker #(
    parameter int BLOCK_FRAMES = 8,
    parameter int SAMPLE_BITS  = 12
) (
    input  wire logic                                                 clk,
    input  wire logic                                                 rst_n,
    input  wire logic                                                 s_tvalid,
    input  wire logic                                                 s_tready,
    input  wire logic [((adcba_pkg::NUM_CH*SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
    input  wire logic                                                 m_tvalid,
    input  wire logic                                                 m_tready,
    input  wire logic [adcba_pkg::OUT_TDATA_W-1:0]                    m_tdata,
    input  wire logic                                                 cfg_valid,
    input  wire logic                                                 cfg_ready,
    input  wire logic [adcba_pkg::CFG_IDX_W-1:0]                      cfg_index,
    input  wire logic [adcba_pkg::CFG_DATA_W-1:0]                     cfg_data,
    output int                                                        mismatches,
    output int                                                        readings_pending,
    output int                                                        readings_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import adcba_pkg::*;

    // Sums are kept in the order of the fields of a sample frame.
    localparam int LANE_CHASSIS_VOLT    = 0;
    localparam int LANE_REFEREE_CURRENT = 1;
    localparam int LANE_CHASSIS_CURRENT = 2;
    localparam int LANE_CAP_CURRENT     = 3;
    localparam int LANE_TEMPERATURE     = 4;
    localparam int LANE_CAP_VOLT        = 5;

    localparam int GAIN_FRAC    = 16;

    // Bit positions of the result fields.
    localparam int CHASSIS_VOLT_LO    = 0;
    localparam int CAP_VOLT_LO        = OUT_W;
    localparam int REFEREE_CURRENT_LO = 2 * OUT_W;
    localparam int CHASSIS_CURRENT_LO = 3 * OUT_W;
    localparam int CAP_CURRENT_LO     = 4 * OUT_W;
    localparam int TEMPERATURE_LO     = 5 * OUT_W;
    localparam int PAD_LO             = 5 * OUT_W + TEMP_W;

    typedef struct {
        logic signed [OUT_W-1:0] chassis_volt_mv;
        logic signed [OUT_W-1:0] cap_volt_mv;
        logic signed [OUT_W-1:0] referee_current_ma;
        logic signed [OUT_W-1:0] chassis_current_ma;
        logic signed [OUT_W-1:0] cap_current_ma;
        logic [TEMP_W-1:0]       temperature_sum;
    } reading_t;

    reading_t          readings_due[$];
    int unsigned       lane_sums[NUM_CH];
    int unsigned       frames_in_block;

    logic [GAIN_W-1:0] cv_gain;
    logic [GAIN_W-1:0] capv_gain;
    logic [GAIN_W-1:0] amp_gain;
    int                cv_offset;
    int                capv_offset;
    int                amp_offset;

    // Gain times mean code plus offset, halves rounded up, saturated to 18 bits.
    function automatic logic signed [OUT_W-1:0] calibrate(input int unsigned block_sum,
                                                          input logic [GAIN_W-1:0] gain,
                                                          input int offset);
        longint divisor;
        longint scaled;
        divisor = longint'(BLOCK_FRAMES) <<< GAIN_FRAC;
        scaled  = (longint'(block_sum) * longint'(gain) + divisor / 2) / divisor
                  + longint'(offset);
        if (scaled > longint'(OUT_MAX))
            scaled = longint'(OUT_MAX);
        else if (scaled < longint'(OUT_MIN))
            scaled = longint'(OUT_MIN);
        return OUT_W'(scaled);
    endfunction

    task automatic note_mismatch(input string what);
        $display("%0t ns  mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string field, input logic [OUT_W-1:0] got,
                               input logic [OUT_W-1:0] want);
        if (got !== want)
            note_mismatch($sformatf("reading %0d %s: got %0d, expected %0d",
                                    readings_checked, field, $signed(got), $signed(want)));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        reading_t    due;
        int unsigned temp_sum;
        if (!rst_n)
        begin
            foreach (lane_sums[lane])
                lane_sums[lane] = 0;
            frames_in_block = 0;
            cv_gain     = RST_CHASSIS_VOLT_GAIN;
            cv_offset   = int'(RST_CHASSIS_VOLT_OFFSET);
            capv_gain   = RST_CAP_VOLT_GAIN;
            capv_offset = int'(RST_CAP_VOLT_OFFSET);
            amp_gain    = RST_CURRENT_GAIN;
            amp_offset  = int'(RST_CURRENT_OFFSET);
            readings_due.delete();
            readings_pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CHASSIS_VOLT_GAIN:   cv_gain     = cfg_data[GAIN_W-1:0];
                    CFG_CHASSIS_VOLT_OFFSET:
                        cv_offset   = int'($signed(cfg_data[VOFFS_W-1:0]));
                    CFG_CAP_VOLT_GAIN:       capv_gain   = cfg_data[GAIN_W-1:0];
                    CFG_CAP_VOLT_OFFSET:
                        capv_offset = int'($signed(cfg_data[VOFFS_W-1:0]));
                    CFG_CURRENT_GAIN:        amp_gain    = cfg_data[GAIN_W-1:0];
                    CFG_CURRENT_OFFSET:
                        amp_offset  = int'($signed(cfg_data[OUT_W-1:0]));
                    default: ;
                endcase
            end

            // The result leaving now can only belong to an earlier block.
            if (m_tvalid && m_tready)
            begin
                if (readings_due.size() == 0)
                    note_mismatch($sformatf("result with no block pending: %h", m_tdata));
                else
                begin
                    due = readings_due.pop_front();
                    check_field("chassis_volt_mv", m_tdata[CHASSIS_VOLT_LO +: OUT_W],
                                due.chassis_volt_mv);
                    check_field("cap_volt_mv", m_tdata[CAP_VOLT_LO +: OUT_W],
                                due.cap_volt_mv);
                    check_field("referee_current_ma", m_tdata[REFEREE_CURRENT_LO +: OUT_W],
                                due.referee_current_ma);
                    check_field("chassis_current_ma", m_tdata[CHASSIS_CURRENT_LO +: OUT_W],
                                due.chassis_current_ma);
                    check_field("cap_current_ma", m_tdata[CAP_CURRENT_LO +: OUT_W],
                                due.cap_current_ma);
                    check_field("temperature_sum",
                                OUT_W'(m_tdata[TEMPERATURE_LO +: TEMP_W]),
                                OUT_W'(due.temperature_sum));
                    check_field("padding", OUT_W'(m_tdata[OUT_TDATA_W-1:PAD_LO]), '0);
                    readings_checked++;
                end
            end

            if (s_tvalid && s_tready)
            begin
                for (int lane = 0; lane < NUM_CH; lane++)
                    lane_sums[lane] += 32'(s_tdata[lane*SAMPLE_BITS +: SAMPLE_BITS]);
                frames_in_block++;
                if (frames_in_block == BLOCK_FRAMES)
                begin
                    due.chassis_volt_mv    = calibrate(lane_sums[LANE_CHASSIS_VOLT],
                                                       cv_gain, cv_offset);
                    due.cap_volt_mv        = calibrate(lane_sums[LANE_CAP_VOLT],
                                                       capv_gain, capv_offset);
                    due.referee_current_ma = calibrate(lane_sums[LANE_REFEREE_CURRENT],
                                                       amp_gain, amp_offset);
                    due.chassis_current_ma = calibrate(lane_sums[LANE_CHASSIS_CURRENT],
                                                       amp_gain, amp_offset);
                    due.cap_current_ma     = calibrate(lane_sums[LANE_CAP_CURRENT],
                                                       amp_gain, amp_offset);
                    temp_sum = lane_sums[LANE_TEMPERATURE];
                    due.temperature_sum = (temp_sum > TEMP_MAX) ? TEMP_W'(TEMP_MAX)
                                                                : TEMP_W'(temp_sum);
                    readings_due.push_back(due);
                    foreach (lane_sums[lane])
                        lane_sums[lane] = 0;
                    frames_in_block = 0;
                end
            end
            readings_pending = readings_due.size();
        end
    end

endmodule

### bench/adc_block_average_calibrate_core_test.sv
module adc_block_average_calibrate_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import adcba_pkg::*;

    localparam int BLOCK_FRAMES   = 8;
    localparam int SAMPLE_BITS    = 12;
    localparam int FRAME_W        = ((NUM_CH * SAMPLE_BITS + 7) / 8) * 8;
    localparam int CODE_MAX       = (1 << SAMPLE_BITS) - 1;
    // Registers 0 to 5 exist; the remaining indexes of the channel must be ignored.
    localparam int NUM_REGS       = 6;
    localparam int IDX_TOP        = (1 << CFG_IDX_W) - 1;
    // The output side holds off this long once, which is far more than the
    // snapshot register and the pipeline can absorb.
    localparam int HOLDOFF_CYCLES = 150;
    // A result appears once its closing frame has passed the snapshot register and the
    // pipeline; wait longer before touching the calibration registers or ending the run.
    localparam int SETTLE_CYCLES  = 12;

    // How the codes of one block of frames are chosen.
    typedef enum int {
        MIX_UNIFORM,
        MIX_RAILS,
        MIX_FULL,
        MIX_ZERO,
        MIX_LOW,
        MIX_HELD
    } frame_mix_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [FRAME_W-1:0]     s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int                     mismatches;
    int                     readings_pending;
    int                     readings_checked;

    // Stimulus bookkeeping; steady_rate and long_holdoff are shared between the sending and receiving processes.
    bit                     steady_rate = 1'b0;
    bit                     long_holdoff = 1'b0;
    frame_mix_t             block_mix = MIX_UNIFORM;
    logic [SAMPLE_BITS-1:0] held_codes[NUM_CH];
    int                     frames_sent = 0;
    int                     reg_writes = 0;

    always #6 clk = ~clk;

    adc_block_average_calibrate_core #(
        .BLOCK_FRAMES (BLOCK_FRAMES),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The checker watches all three channels, keeps its own copy of the sums and
    // the calibration, and compares every result request with its prediction.
    adcba_calibration_checker #(
        .BLOCK_FRAMES (BLOCK_FRAMES),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .readings_pending (readings_pending),
        .readings_checked (readings_checked)
    );

    // Idle cycles before a request: mostly none, often a few, now and then a long
    // stretch. During a steady phase both sides run without gaps.
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (steady_rate || pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] sample_code(input frame_mix_t mix,
                                                           input int lane);
        int pick;
        pick = $urandom_range(0, 99);
        case (mix)
            MIX_ZERO: return '0;
            MIX_FULL: return SAMPLE_BITS'(CODE_MAX);
            MIX_LOW:  return SAMPLE_BITS'($urandom_range(0, 15));
            MIX_HELD: return held_codes[lane];
            MIX_RAILS:
            begin
                // Rails and alternating bit patterns, mixed with ordinary codes.
                if (pick < 25)
                    return '0;
                if (pick < 50)
                    return SAMPLE_BITS'(CODE_MAX);
                if (pick < 65)
                    return {(SAMPLE_BITS/2){2'b10}};
                if (pick < 80)
                    return {(SAMPLE_BITS/2){2'b01}};
                return SAMPLE_BITS'($urandom_range(0, CODE_MAX));
            end
            default: return SAMPLE_BITS'($urandom_range(0, CODE_MAX));
        endcase
    endfunction

    // Sends a number of sample frames. When the mix varies, each new block of
    // frames picks its own mix, so that some blocks drive the sums to their
    // extremes and saturate the converted fields.
    task automatic send_frames(input int count, input bit vary_mix);
        logic [FRAME_W-1:0] frame;
        int                 gap;
        for (int n = 0; n < count; n++)
        begin
            if (vary_mix && frames_sent % BLOCK_FRAMES == 0)
            begin
                block_mix = frame_mix_t'($urandom_range(MIX_UNIFORM, MIX_HELD));
                foreach (held_codes[lane])
                    held_codes[lane] = SAMPLE_BITS'($urandom_range(0, CODE_MAX));
            end
            frame = '0;
            for (int lane = 0; lane < NUM_CH; lane++)
                frame[lane*SAMPLE_BITS +: SAMPLE_BITS] = sample_code(block_mix, lane);
            gap = idle_gap();
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= frame;
            do
                @(posedge clk);
            while (!s_tready);
            frames_sent++;
        end
    endtask

    // Stops sending and waits until every predicted result has been taken, then
    // lets the pipeline settle. The first edge makes sure the checker has seen
    // the last frame request before its count of pending results is trusted.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (readings_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write request. The caller lowers cfg_valid after a batch.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        reg_writes++;
    endtask

    // Output side: accepts in random runs with random gaps, and holds off for a
    // long stretch once when the stimulus asks for it.
    initial
    begin : receiver
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_holdoff)
            begin
                long_holdoff = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            gap = idle_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset calibration: an all-zero block shows the
        // bare offsets (the current offset is negative), and a full-scale block
        // gives the largest sums the default parameters allow.
        block_mix = MIX_ZERO;
        send_frames(BLOCK_FRAMES, 1'b0);
        block_mix = MIX_FULL;
        send_frames(BLOCK_FRAMES, 1'b0);
        drain();

        // Writes to the unused indexes must change nothing, and bits above an
        // offset's width must be dropped.
        write_reg(CFG_IDX_W'(NUM_REGS), CFG_DATA_W'($urandom));
        write_reg(CFG_IDX_W'(IDX_TOP), CFG_DATA_W'($urandom));
        write_reg(CFG_CHASSIS_VOLT_OFFSET, 24'hA5_0010);
        write_reg(CFG_CURRENT_OFFSET, 24'h5E_1234);
        cfg_valid <= 1'b0;
        block_mix = MIX_RAILS;
        send_frames(BLOCK_FRAMES, 1'b0);
        drain();

        // Largest gains and offsets: most converted fields saturate high. This
        // phase runs both sides without gaps.
        write_reg(CFG_CHASSIS_VOLT_GAIN, 24'hFF_FFFF);
        write_reg(CFG_CHASSIS_VOLT_OFFSET, 24'h00_7FFF);
        write_reg(CFG_CAP_VOLT_GAIN, 24'hFF_FFFF);
        write_reg(CFG_CAP_VOLT_OFFSET, 24'h00_7FFF);
        write_reg(CFG_CURRENT_GAIN, 24'hFF_FFFF);
        write_reg(CFG_CURRENT_OFFSET, 24'h01_FFFF);
        cfg_valid <= 1'b0;
        steady_rate = 1'b1;
        send_frames(8 * BLOCK_FRAMES, 1'b1);
        steady_rate = 1'b0;
        drain();

        // Zero gains and the most negative offsets; the offset words carry set
        // upper bits that must be ignored.
        write_reg(CFG_CHASSIS_VOLT_GAIN, 24'h00_0000);
        write_reg(CFG_CHASSIS_VOLT_OFFSET, 24'hFF_8000);
        write_reg(CFG_CAP_VOLT_GAIN, 24'h00_0000);
        write_reg(CFG_CAP_VOLT_OFFSET, 24'hFF_8000);
        write_reg(CFG_CURRENT_GAIN, 24'h00_0000);
        write_reg(CFG_CURRENT_OFFSET, 24'hFE_0000);
        cfg_valid <= 1'b0;
        send_frames(6 * BLOCK_FRAMES, 1'b1);
        drain();

        // Random calibrations. Phase lengths need not be whole blocks, so partial
        // blocks can carry over a calibration change.
        for (int phase = 0; phase < 6; phase++)
        begin
            repeat ($urandom_range(1, 8))
                write_reg(CFG_IDX_W'($urandom_range(0, IDX_TOP)), CFG_DATA_W'($urandom));
            cfg_valid <= 1'b0;
            if (phase == 1)
            begin
                // The sender keeps offering frames at full rate while the output
                // is held off, so the block must stall its input. Sending starts
                // once the hold-off has begun, so the pipeline surely fills.
                steady_rate  = 1'b1;
                long_holdoff = 1'b1;
                wait (long_holdoff == 1'b0);
            end
            if (phase == 3)
            begin
                // Pause mid-phase until every expected result has come back.
                send_frames(36, 1'b1);
                drain();
                send_frames(36, 1'b1);
            end
            else
                send_frames($urandom_range(64, 80), 1'b1);
            steady_rate = 1'b0;
            drain();
        end

        $display("Sent %0d sample frames, checked %0d block results, made %0d register writes.",
                 frames_sent, readings_checked, reg_writes);
        $display("Covered reset, extreme and random calibrations, ignored indexes, a %0d-cycle %s",
                 HOLDOFF_CYCLES, "output hold-off and a full drain in mid-stream.");
        if (mismatches == 0)
            $display("adc_block_average_calibrate_core_test: done, clean");
        else
            $display("adc_block_average_calibrate_core_test: done, errors");
        $finish;
    end

    // Safety net against a hung handshake.
    initial
    begin : watchdog
        #5ms;
        $display("Timed out waiting on a handshake.");
        $display("adc_block_average_calibrate_core_test: done, errors");
        $finish;
    end

endmodule
